@@ sv/nmps_pkg.sv @@
`timescale 1ns / 1ps
package nmps_pkg;
  localparam int ELEM_WIDTH = 32;
  localparam int FRAC_BITS = 16;
  localparam int TOL_W = 16;
  localparam int DEV_W = 24;
  localparam int DEV_FRAC = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd66;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_row0;
    logic load_row1;
    logic load_row2;
    logic take_ref;
    logic clear_totals;
    logic start_cmp;
    logic scan_step;
    logic diff_step;
    logic div_init;
    logic div_step;
    logic finish;
  } nmps_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ref_zero;
    logic bad_scalar;
    logic scan_last;
    logic div_last;
  } nmps_stat_t;
endpackage

@@ sv/nmps_if.sv @@
`timescale 1ns / 1ps
interface nmps_in_if #(parameter int ELEM_WIDTH = nmps_pkg::ELEM_WIDTH) ();
  logic valid;
  logic ready;
  logic restart;
  logic usable;
  logic [1:0] row;
  logic signed [ELEM_WIDTH-1:0] elem_col0;
  logic signed [ELEM_WIDTH-1:0] elem_col1;
  logic signed [ELEM_WIDTH-1:0] elem_col2;
  modport source (output valid, restart, usable, row, elem_col0, elem_col1, elem_col2,
                  input ready);
  modport sink (input valid, restart, usable, row, elem_col0, elem_col1, elem_col2,
                output ready);
endinterface

interface nmps_out_if ();
  logic valid;
  logic ready;
  logic conflict;
  logic [nmps_pkg::DEV_W-1:0] max_deviation;
  logic matched;
  logic took_reference;
  modport source (output valid, conflict, max_deviation, matched, took_reference,
                  input ready);
  modport sink (input valid, conflict, max_deviation, matched, took_reference,
                output ready);
endinterface

@@ sv/nmps_datapath.sv @@
`timescale 1ns / 1ps
module nmps_datapath #(
  parameter int ELEM_WIDTH = nmps_pkg::ELEM_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  nmps_pkg::nmps_cmd_t cmd,
  output nmps_pkg::nmps_stat_t stat,
  input  logic signed [ELEM_WIDTH-1:0] e0,
  input  logic signed [ELEM_WIDTH-1:0] e1,
  input  logic signed [ELEM_WIDTH-1:0] e2,
  input  logic [nmps_pkg::TOL_W-1:0] tolerance,
  output logic conflict,
  output logic [nmps_pkg::DEV_W-1:0] max_deviation,
  output logic matched
);
  localparam int EW = ELEM_WIDTH;
  localparam int PW = 2 * EW;
  localparam int NW = PW + 1;
  localparam int DW = nmps_pkg::DEV_W;
  localparam int FW = nmps_pkg::DEV_FRAC;
  localparam int TW = nmps_pkg::TOL_W;
  // Wide enough for den shifted up by DW and for the numerator shifted by FW.
  localparam int RW = PW + DW + 1;

  logic signed [EW-1:0] ref_m [9];
  logic signed [EW-1:0] cur_m [9];
  logic [3:0] idx;
  logic [EW-1:0] ma;
  logic signed [EW-1:0] a_sel, b_sel;
  logic [NW-1:0] num;
  logic [PW-1:0] den;
  logic [RW-1:0] rem;
  logic [DW-1:0] quo;
  logic [4:0] bit_cnt;
  logic sat;

  // Current scan elements and their magnitudes, and magnitudes of the pivot pair.
  logic signed [EW-1:0] ra, cb;
  logic [EW-1:0] mag_a, mag_b, mag_bs, mag_as;
  logic [PW-1:0] p_prod, q_prod;
  logic [NW-1:0] d_val;

  assign ra = ref_m[idx];
  assign cb = cur_m[idx];
  assign mag_a = ra[EW-1] ? EW'(-ra) : EW'(ra);
  assign mag_b = cb[EW-1] ? EW'(-cb) : EW'(cb);
  assign mag_bs = b_sel[EW-1] ? EW'(-b_sel) : EW'(b_sel);
  assign mag_as = a_sel[EW-1] ? EW'(-a_sel) : EW'(a_sel);

  // Cross products |B_ij|*|a| and |b|*|A_ij|, registered before the add.
  logic [PW-1:0] p_r, q_r;
  logic sp_r, sq_r, diff_v;
  assign p_prod = PW'(mag_b) * PW'(mag_as);
  assign q_prod = PW'(mag_bs) * PW'(mag_a);

  always_comb begin
    if (sp_r != sq_r) d_val = NW'(p_r) + NW'(q_r);
    else if (p_r >= q_r) d_val = NW'(p_r - q_r);
    else d_val = NW'(q_r - p_r);
  end

  // Restoring divide step against den shifted to the current bit.
  logic [RW-1:0] den_sh;
  assign den_sh = RW'(den) << bit_cnt;

  // Tolerance test: num<<FW <= den*tolerance.
  logic [PW+TW-1:0] tol_prod;
  assign tol_prod = (PW+TW)'(den) * (PW+TW)'(tolerance);

  assign stat.ref_zero = (ma == '0);
  assign stat.bad_scalar = (b_sel == '0) || (a_sel[EW-1] != b_sel[EW-1]);
  assign stat.scan_last = (idx == 4'd8);
  assign stat.div_last = (bit_cnt == 5'd0);

  always_ff @(posedge clk) begin
    // Matrix assembly.
    if (cmd.load_row0) begin
      cur_m[0] <= e0; cur_m[1] <= e1; cur_m[2] <= e2;
    end
    if (cmd.load_row1) begin
      cur_m[3] <= e0; cur_m[4] <= e1; cur_m[5] <= e2;
    end
    if (cmd.load_row2) begin
      cur_m[6] <= e0; cur_m[7] <= e1; cur_m[8] <= e2;
    end
    if (cmd.take_ref) begin
      for (int i = 0; i < 9; i++) ref_m[i] <= cur_m[i];
    end
    // Pivot search, then deviation scan, both one element a cycle.
    if (cmd.start_cmp) begin
      idx <= '0; ma <= '0; a_sel <= '0; b_sel <= '0; num <= '0; diff_v <= 1'b0;
    end else if (cmd.scan_step) begin
      if (mag_a > ma) begin
        ma <= mag_a; a_sel <= ra; b_sel <= cb;
      end
      idx <= stat.scan_last ? 4'd0 : idx + 4'd1;
    end else if (cmd.diff_step) begin
      p_r <= p_prod; q_r <= q_prod;
      sp_r <= cb[EW-1] ^ a_sel[EW-1];
      sq_r <= b_sel[EW-1] ^ ra[EW-1];
      diff_v <= 1'b1;
      if (diff_v && d_val > num) num <= d_val;
      idx <= stat.scan_last ? 4'd0 : idx + 4'd1;
    end
    if (cmd.div_init) begin
      // Fold in the last product pair.
      logic [NW-1:0] nf;
      nf = (d_val > num) ? d_val : num;
      num <= nf;
      den <= PW'(ma) * PW'(mag_bs);
      rem <= RW'(nf) << FW;
      bit_cnt <= 5'(DW - 1);
      quo <= '0;
    end else if (cmd.div_step) begin
      if (bit_cnt == 5'(DW - 1)) sat <= (rem >= (den_sh << 1));
      if (rem >= den_sh) begin
        rem <= rem - den_sh;
        quo[bit_cnt] <= 1'b1;
      end
      if (!stat.div_last) bit_cnt <= bit_cnt - 5'd1;
    end
  end

  // Totals.
  logic [DW-1:0] dev;
  logic match;
  always_comb begin
    if (stat.ref_zero) dev = '0;
    else if (stat.bad_scalar) dev = DW'(1) << FW;
    else if (sat) dev = '1;
    else dev = quo;
    match = !stat.ref_zero && !stat.bad_scalar &&
            ((RW'(num) << FW) <= RW'(tol_prod));
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_totals) begin
      conflict <= 1'b0;
      max_deviation <= '0;
      matched <= 1'b0;
    end else if (cmd.finish) begin
      matched <= match;
      if (!match) conflict <= 1'b1;
      if (dev > max_deviation) max_deviation <= dev;
    end else if (cmd.load_row2 || cmd.take_ref) begin
      matched <= 1'b0;
    end
  end
endmodule

@@ sv/nmps_ctrl.sv @@
`timescale 1ns / 1ps
module nmps_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic restart,
  input  logic usable,
  input  logic [1:0] row,
  input  logic out_ready,
  input  nmps_pkg::nmps_stat_t stat,
  output nmps_pkg::nmps_cmd_t cmd,
  output logic in_ready,
  output logic out_valid,
  output logic took_reference
);
  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DIFF, S_DIV, S_DONE, S_OUT} state_t;
  state_t state;
  logic seen0, seen1, all_usable, have_ref, last_diff;

  assign in_ready = (state == S_IDLE) || (state == S_OUT && out_ready);
  assign out_valid = (state == S_OUT);

  // Decode commands from state and the accepted transaction.
  always_comb begin
    cmd = '0;
    if (in_fire) begin
      cmd.load_row0 = (row == 2'd0);
      cmd.load_row1 = (row == 2'd1);
      cmd.load_row2 = (row == 2'd2);
      cmd.start_cmp = (row == 2'd2);
      cmd.clear_totals = (row == 2'd0) && restart;
    end
    unique case (state)
      S_IDLE, S_OUT: ;
      S_SCAN: cmd.scan_step = 1'b1;
      S_DIFF: cmd.diff_step = !last_diff;
      S_DIV: cmd.div_step = 1'b1;
      S_DONE: cmd.finish = 1'b1;
      default: ;
    endcase
    if (state == S_DIFF && last_diff) cmd.div_init = 1'b1;
    // The new reference is copied as its result leaves.
    if (state == S_OUT && out_ready && took_reference) cmd.take_ref = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      seen0 <= 1'b0; seen1 <= 1'b0; all_usable <= 1'b0;
      have_ref <= 1'b0; took_reference <= 1'b0; last_diff <= 1'b0;
    end else begin
      if (state == S_OUT && out_ready && !(in_fire && row == 2'd2)) state <= S_IDLE;
      if (in_fire) begin
        unique case (row)
          2'd0: begin
            if (restart) have_ref <= 1'b0;
            seen0 <= 1'b1; seen1 <= 1'b0; all_usable <= usable;
          end
          2'd1: begin
            seen1 <= seen0; seen0 <= 1'b0; all_usable <= all_usable && usable;
          end
          2'd2: begin
            seen0 <= 1'b0; seen1 <= 1'b0; all_usable <= 1'b0;
            if (seen1 && all_usable && usable && have_ref) begin
              took_reference <= 1'b0;
              state <= S_SCAN;
            end else begin
              if (seen1 && all_usable && usable) begin
                have_ref <= 1'b1;
                took_reference <= 1'b1;
              end else begin
                took_reference <= 1'b0;
              end
              state <= S_OUT;
            end
          end
          default: ;
        endcase
      end
      unique case (state)
        S_SCAN: if (stat.scan_last) begin
          state <= S_DIFF; last_diff <= 1'b0;
        end
        S_DIFF: begin
          if (last_diff) state <= S_DIV;
          else if (stat.scan_last) last_diff <= 1'b1;
        end
        S_DIV: if (stat.div_last) state <= S_DONE;
        S_DONE: state <= S_OUT;
        default: ;
      endcase
    end
  end
endmodule

@@ sv/normal_matrix_proportionality_scan_top.sv @@
`timescale 1ns / 1ps
// Rows 0 and 1 are stored and give no result. A row-2 result is valid the cycle after
// acceptance when the matrix is unusable or becomes the reference; when it is
// compared, it follows a pivot search, a deviation scan, 24 quotient bits from a
// one-bit-a-cycle restoring divider and an update of the totals.
// One matrix is in work at a time; input waits while a result is held.
// Reset (rst, synchronous) clears the reference flag and totals; tolerance resets to 66.
module normal_matrix_proportionality_scan_top #(
  parameter int ELEM_WIDTH = nmps_pkg::ELEM_WIDTH
) (
  input  logic clk,
  input  logic rst,
  nmps_in_if.sink in_ch,
  nmps_out_if.source out_ch,
  input  logic cfg_we,
  input  logic [nmps_pkg::TOL_W-1:0] cfg_wdata
);
  nmps_pkg::nmps_cmd_t cmd;
  nmps_pkg::nmps_stat_t stat;
  logic [nmps_pkg::TOL_W-1:0] tolerance;
  logic in_fire;

  // Tolerance register.
  always_ff @(posedge clk) begin
    if (rst) tolerance <= nmps_pkg::TOL_RESET;
    else if (cfg_we) tolerance <= cfg_wdata;
  end

  assign in_fire = in_ch.valid && in_ch.ready;

  nmps_ctrl u_ctrl (
    .clk, .rst, .in_fire,
    .restart(in_ch.restart), .usable(in_ch.usable), .row(in_ch.row),
    .out_ready(out_ch.ready), .stat, .cmd(cmd),
    .in_ready(in_ch.ready), .out_valid(out_ch.valid),
    .took_reference(out_ch.took_reference)
  );

  nmps_datapath #(.ELEM_WIDTH(ELEM_WIDTH)) u_dp (
    .clk, .rst,
    .cmd(cmd), .stat,
    .e0(in_ch.elem_col0), .e1(in_ch.elem_col1), .e2(in_ch.elem_col2),
    .tolerance,
    .conflict(out_ch.conflict), .max_deviation(out_ch.max_deviation),
    .matched(out_ch.matched)
  );
endmodule

@@ sv/nmps_checker.sv @@
`timescale 1ns / 1ps
module nmps_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic matched,
  input logic took_reference,
  input logic conflict
);
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(matched && took_reference)) else $error("match and take");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(matched) && $stable(took_reference) &&
    $stable(conflict)) else $error("result changed while waiting");
  a_block: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> !(out_valid && !out_ready))
    else $error("input accepted while a result waits");
endmodule

bind normal_matrix_proportionality_scan_top nmps_checker u_chk (
  .clk, .rst,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .matched(out_ch.matched), .took_reference(out_ch.took_reference),
  .conflict(out_ch.conflict)
);
